// ===== hdl/merc_pkg.sv =====
// ----------------------------------------------------------------------------
// merc_pkg
// Shared types and constants of the echo ranging controller.
// ----------------------------------------------------------------------------
package merc_pkg;

   localparam int NUM_CHANNELS_DEF = 3;
   localparam int DIST_WIDTH_DEF   = 16;
   localparam int MAX_CHANNELS     = 3;

   localparam int SLOT_W   = 25;
   localparam int PULSE_W  = 16;
   localparam int WIN_W    = 16;
   localparam int ECHO_W   = 3;
   localparam int CH_W     = 2;
   localparam int OUT_DIST_W = 16;
   localparam int CFG_ADDR_W = 3;
   localparam int CFG_DATA_W = 25;

   // ticks to mm: 343000 mm/s * 25 ns / 2, 16 fraction bits
   localparam int MM_FACTOR_W = 9;
   localparam logic [MM_FACTOR_W-1:0] MM_FACTOR = 9'd281;
   localparam int MM_FRAC  = 16;
   localparam int PROD_W   = SLOT_W + MM_FACTOR_W;
   localparam int MM_W     = PROD_W - MM_FRAC;

   localparam logic [SLOT_W-1:0] ECHO_MAX = {SLOT_W{1'b1}};

   localparam logic [CFG_ADDR_W-1:0] REG_SLOT_TICKS  = 3'd0;
   localparam logic [CFG_ADDR_W-1:0] REG_PULSE_TICKS = 3'd1;
   localparam logic [CFG_ADDR_W-1:0] REG_WIN0_LOW    = 3'd2;
   localparam logic [CFG_ADDR_W-1:0] REG_WIN0_HIGH   = 3'd3;
   localparam logic [CFG_ADDR_W-1:0] REG_WIN1_LOW    = 3'd4;
   localparam logic [CFG_ADDR_W-1:0] REG_WIN1_HIGH   = 3'd5;
   localparam logic [CFG_ADDR_W-1:0] REG_WIN2_LOW    = 3'd6;
   localparam logic [CFG_ADDR_W-1:0] REG_WIN2_HIGH   = 3'd7;

   typedef enum logic [3:0] {
      PH_ARM   = 4'b0001,
      PH_PULSE = 4'b0010,
      PH_ECHO  = 4'b0100,
      PH_HOLD  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [SLOT_W-1:0]                     slot_ticks;
      logic [PULSE_W-1:0]                    pulse_ticks;
      logic [MAX_CHANNELS-1:0][WIN_W-1:0]    win_low;
      logic [MAX_CHANNELS-1:0][WIN_W-1:0]    win_high;
   } cfg_type;

   // first field in the highest bits
   typedef struct packed {
      logic [OUT_DIST_W-1:0] distance_mm;
      logic [CH_W-1:0]       active_channel;
      logic                  slot_timed_out;
      logic                  measure_done;
      logic                  motor_on;
      logic [ECHO_W-1:0]     trigger_levels;
   } result_type;

endpackage

// ===== hdl/merc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// merc_cfg_regs
// Configuration register file: slot and pulse lengths, channel windows.
// ----------------------------------------------------------------------------
module merc_cfg_regs
   import merc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CFG_ADDR_W-1:0] csr_addr,
   input  logic [CFG_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_ticks  <= 25'd20000000;
         cfg_ff.pulse_ticks <= 16'd400;
         cfg_ff.win_low[0]  <= 16'd250;
         cfg_ff.win_high[0] <= 16'd375;
         cfg_ff.win_low[1]  <= 16'd50;
         cfg_ff.win_high[1] <= 16'd280;
         cfg_ff.win_low[2]  <= 16'd315;
         cfg_ff.win_high[2] <= 16'd400;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SLOT_TICKS:  cfg_ff.slot_ticks  <= csr_wdata[SLOT_W-1:0];
            REG_PULSE_TICKS: cfg_ff.pulse_ticks <= csr_wdata[PULSE_W-1:0];
            REG_WIN0_LOW:    cfg_ff.win_low[0]  <= csr_wdata[WIN_W-1:0];
            REG_WIN0_HIGH:   cfg_ff.win_high[0] <= csr_wdata[WIN_W-1:0];
            REG_WIN1_LOW:    cfg_ff.win_low[1]  <= csr_wdata[WIN_W-1:0];
            REG_WIN1_HIGH:   cfg_ff.win_high[1] <= csr_wdata[WIN_W-1:0];
            REG_WIN2_LOW:    cfg_ff.win_low[2]  <= csr_wdata[WIN_W-1:0];
            REG_WIN2_HIGH:   cfg_ff.win_high[2] <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/merc_range_core.sv =====
// ----------------------------------------------------------------------------
// merc_range_core
// Slot sequencer, trigger pulse, echo timing and distance conversion.
// ----------------------------------------------------------------------------
module merc_range_core
   import merc_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int DIST_WIDTH   = DIST_WIDTH_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [ECHO_W-1:0] echo_levels,
   input  cfg_type           cfg,
   output result_type        result
);

   localparam int CMP_W = (DIST_WIDTH > WIN_W) ? DIST_WIDTH : WIN_W;
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

   logic [CH_W-1:0]       cur_ch_ff, cur_ch_in;
   phase_type             phase_ff, phase_in;
   logic [SLOT_W-1:0]     slot_cnt_ff, slot_cnt_in;
   logic [PULSE_W-1:0]    pulse_cnt_ff, pulse_cnt_in;
   logic [SLOT_W-1:0]     echo_cnt_ff, echo_cnt_in;
   logic [ECHO_W-1:0]     prev_echo_ff;
   logic                  echo_seen_ff, echo_seen_in;
   logic [DIST_WIDTH-1:0] range_ff [MAX_CHANNELS];
   logic [DIST_WIDTH-1:0] range_in [MAX_CHANNELS];
   logic                  motor_ff, motor_in;

   logic [CH_W-1:0]       ch;
   logic [ECHO_W-1:0]     diff;
   logic                  edge_hit;
   logic [PROD_W-1:0]     prod;
   logic [MM_W-1:0]       mm;
   logic [DIST_WIDTH-1:0] dist_sat;
   logic                  hit;
   logic [ECHO_W-1:0]     trig;
   logic                  done;
   logic                  tmo;

   always_comb begin
      int c;
      ch        = (cur_ch_ff > LAST_CH) ? '0 : cur_ch_ff;
      diff      = (echo_levels ^ prev_echo_ff) >> ch;
      edge_hit  = diff[0];
      phase_in     = phase_ff;
      pulse_cnt_in = pulse_cnt_ff;
      echo_seen_in = echo_seen_ff;
      echo_cnt_in  = echo_cnt_ff;
      slot_cnt_in  = slot_cnt_ff;
      cur_ch_in    = cur_ch_ff;
      motor_in     = motor_ff;
      range_in     = range_ff;
      trig = '0;
      done = 1'b0;
      tmo  = 1'b0;
      hit  = 1'b0;

      if (phase_in == PH_ARM) begin
         phase_in     = PH_PULSE;
         pulse_cnt_in = cfg.pulse_ticks;
         echo_seen_in = 1'b0;
      end

      if (echo_cnt_ff != ECHO_MAX) begin
         echo_cnt_in = echo_cnt_ff + 1'b1;
      end
      prod = PROD_W'(echo_cnt_in) * PROD_W'(MM_FACTOR);
      mm   = prod[PROD_W-1:MM_FRAC];
      if ((DIST_WIDTH < MM_W) && ((mm >> DIST_WIDTH) != '0)) begin
         dist_sat = '1;
      end else begin
         dist_sat = DIST_WIDTH'(mm);
      end

      case (phase_in)
         PH_PULSE: begin
            echo_cnt_in = echo_cnt_ff;
            if (pulse_cnt_in != '0) begin
               trig         = ECHO_W'(1) << ch;
               pulse_cnt_in = pulse_cnt_in - 1'b1;
            end else if (edge_hit) begin
               phase_in    = PH_ECHO;
               echo_cnt_in = '0;
            end
         end
         PH_ECHO: begin
            if (edge_hit) begin
               range_in[ch] = dist_sat;
               echo_seen_in = 1'b1;
               phase_in     = PH_HOLD;
               done         = 1'b1;
               for (c = 0; c < MAX_CHANNELS; c++) begin
                  if ((c < NUM_CHANNELS)
                      && (CMP_W'(range_in[c]) > CMP_W'(cfg.win_low[c]))
                      && (CMP_W'(range_in[c]) < CMP_W'(cfg.win_high[c]))) begin
                     hit = 1'b1;
                  end
               end
               motor_in = hit;
            end
         end
         default: begin
            echo_cnt_in = echo_cnt_ff;
         end
      endcase

      slot_cnt_in = slot_cnt_ff + 1'b1;
      if ((slot_cnt_in >= cfg.slot_ticks) || (slot_cnt_in == '0)) begin
         if (!echo_seen_in) begin
            range_in[ch] = '0;
            tmo          = 1'b1;
         end
         cur_ch_in    = (ch == LAST_CH) ? '0 : ch + 1'b1;
         phase_in     = PH_ARM;
         echo_seen_in = 1'b1;
         slot_cnt_in  = '0;
         pulse_cnt_in = '0;
      end

      result.trigger_levels = trig;
      result.motor_on       = motor_in;
      result.measure_done   = done;
      result.slot_timed_out = tmo;
      result.active_channel = ch;
      result.distance_mm    = OUT_DIST_W'(range_in[ch]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ch_ff    <= '0;
         phase_ff     <= PH_ARM;
         slot_cnt_ff  <= '0;
         pulse_cnt_ff <= '0;
         echo_cnt_ff  <= '0;
         prev_echo_ff <= '0;
         echo_seen_ff <= 1'b1;
         motor_ff     <= 1'b0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            range_ff[i] <= '0;
         end
      end else if (step) begin
         cur_ch_ff    <= cur_ch_in;
         phase_ff     <= phase_in;
         slot_cnt_ff  <= slot_cnt_in;
         pulse_cnt_ff <= pulse_cnt_in;
         echo_cnt_ff  <= echo_cnt_in;
         prev_echo_ff <= echo_levels;
         echo_seen_ff <= echo_seen_in;
         motor_ff     <= motor_in;
         range_ff     <= range_in;
      end
   end

endmodule

// ===== hdl/merc_out_skid.sv =====
// ----------------------------------------------------------------------------
// merc_out_skid
// Two-entry result buffer between the core and the result channel.
// ----------------------------------------------------------------------------
module merc_out_skid
   import merc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_item
);

   result_type head_ff, tail_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = head_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (push && !pop) begin
         cnt_ff <= cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push && pop) begin
         if (cnt_ff == 2'd1) begin
            head_ff <= in_item;
         end else begin
            head_ff <= tail_ff;
            tail_ff <= in_item;
         end
      end else if (pop) begin
         head_ff <= tail_ff;
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            head_ff <= in_item;
         end else begin
            tail_ff <= in_item;
         end
      end
   end

endmodule

// ===== hdl/multi_channel_echo_ranging_controller_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_echo_ranging_controller_core
// Ultrasonic time-of-flight ranging over up to three sensors in turn.
//
//   channel  dir  handshake            payload
//   req_     in   tvalid / tready      tdata[2:0] echo_levels
//   rsp_     out  tvalid / tready      tdata[23:0] result fields
//   csr_     in   we (no wait)         addr[2:0], wdata[24:0]
//
// One item per clock while req_tready is high; its result sits in the output buffer on the next cycle.
// All state updates in a single registered pass per item.
// Synchronous reset clears every counter and the stored distances at once.
// req_tready drops only while both output buffer entries are occupied.
// ----------------------------------------------------------------------------
module multi_channel_echo_ranging_controller_core
   import merc_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int DIST_WIDTH   = DIST_WIDTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // fields from bit 0: echo_levels[2:0], zero fill
   input  logic [7:0]            req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // fields from bit 0: trigger_levels[2:0], motor_on, measure_done,
   // slot_timed_out, active_channel[1:0], distance_mm[15:0]
   output logic [23:0]           rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CFG_ADDR_W-1:0] csr_addr,
   input  logic [CFG_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   result_type core_result;
   result_type out_item;
   logic       step;

   assign step = req_tvalid && req_tready;

   merc_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   merc_range_core #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .DIST_WIDTH   (DIST_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .echo_levels (req_tdata[ECHO_W-1:0]),
      .cfg         (cfg),
      .result      (core_result)
   );

   merc_out_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (core_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = out_item;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the echo ranging controller core. Echo levels are
// streamed in one item per tick. A tick-level predictor of slot, pulse, echo
// timing, distance and motor window logic works out each result, and every
// result item is checked field by field, in order. Register settings change
// only while the block is drained. Both stream sides idle at random, and the
// receiver also holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_top;
   import merc_pkg::*;

   localparam int TICKS_TO_MM  = 281;   // 343000 mm/s * 25 ns / 2, 16 fraction bits
   localparam int MM_SHIFT     = 16;
   localparam int IDLE_MAX     = 13;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_REGS     = 8;

   localparam int SLOT_FULL   = 0;   // pulse, echo start, echo stop
   localparam int SLOT_SILENT = 1;   // no echo at all
   localparam int SLOT_OPEN   = 2;   // echo starts but never stops

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [7:0]            req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CFG_ADDR_W-1:0] csr_addr   = '0;
   logic [CFG_DATA_W-1:0] csr_wdata  = '0;

   // predictor state
   logic [CFG_DATA_W-1:0] shadow_regs [NUM_REGS];
   logic [CFG_DATA_W-1:0] pending_regs [NUM_REGS];
   logic [CH_W-1:0]       rng_channel;
   phase_type             rng_phase;
   logic [SLOT_W-1:0]     rng_slot_count;
   logic [PULSE_W-1:0]    rng_pulse_left;
   logic [SLOT_W-1:0]     rng_echo_ticks;
   logic [ECHO_W-1:0]     rng_prev_levels;
   logic                  rng_echo_seen;
   logic [OUT_DIST_W-1:0] rng_dist [MAX_CHANNELS];
   logic                  rng_motor;
   int                    slots_ended = 0;

   result_type            expected_ticks [$];
   logic [ECHO_W-1:0]     echo_lines = '0;
   int                    n_sent     = 0;
   int                    n_errors   = 0;
   bit                    src_idle   = 1'b0;
   bit                    sink_idle  = 1'b0;
   int                    sink_hold  = 0;

   multi_channel_echo_ranging_controller_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("tb_top: errors");
      $finish;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic void ranging_reset();
      shadow_regs[REG_SLOT_TICKS]  = 25'd20000000;
      shadow_regs[REG_PULSE_TICKS] = 25'd400;
      shadow_regs[REG_WIN0_LOW]    = 25'd250;
      shadow_regs[REG_WIN0_HIGH]   = 25'd375;
      shadow_regs[REG_WIN1_LOW]    = 25'd50;
      shadow_regs[REG_WIN1_HIGH]   = 25'd280;
      shadow_regs[REG_WIN2_LOW]    = 25'd315;
      shadow_regs[REG_WIN2_HIGH]   = 25'd400;
      rng_channel     = '0;
      rng_phase       = PH_ARM;
      rng_slot_count  = '0;
      rng_pulse_left  = '0;
      rng_echo_ticks  = '0;
      rng_prev_levels = '0;
      rng_echo_seen   = 1'b1;
      rng_motor       = 1'b0;
      foreach (rng_dist[c]) rng_dist[c] = '0;
   endfunction

   function automatic logic any_channel_in_window();
      logic [WIN_W-1:0] lo [MAX_CHANNELS];
      logic [WIN_W-1:0] hi [MAX_CHANNELS];
      logic             hit;
      lo[0] = shadow_regs[REG_WIN0_LOW][WIN_W-1:0];
      hi[0] = shadow_regs[REG_WIN0_HIGH][WIN_W-1:0];
      lo[1] = shadow_regs[REG_WIN1_LOW][WIN_W-1:0];
      hi[1] = shadow_regs[REG_WIN1_HIGH][WIN_W-1:0];
      lo[2] = shadow_regs[REG_WIN2_LOW][WIN_W-1:0];
      hi[2] = shadow_regs[REG_WIN2_HIGH][WIN_W-1:0];
      hit = 1'b0;
      for (int c = 0; c < MAX_CHANNELS; c++)
         if (rng_dist[c] > lo[c] && rng_dist[c] < hi[c]) hit = 1'b1;
      return hit;
   endfunction

   function automatic result_type predict_ranging_tick(logic [ECHO_W-1:0] levels);
      result_type      r;
      logic [CH_W-1:0] ch;
      logic            hit_edge;
      logic [63:0]     mm;
      r = '0;
      ch = (rng_channel >= MAX_CHANNELS) ? '0 : rng_channel;
      hit_edge = levels[ch] ^ rng_prev_levels[ch];
      rng_prev_levels = levels;

      if (rng_phase == PH_ARM) begin
         rng_phase      = PH_PULSE;
         rng_pulse_left = shadow_regs[REG_PULSE_TICKS][PULSE_W-1:0];
         rng_echo_seen  = 1'b0;
      end
      if (rng_phase == PH_PULSE) begin
         if (rng_pulse_left != 0) begin
            r.trigger_levels[ch] = 1'b1;
            rng_pulse_left--;
         end else if (hit_edge) begin
            rng_phase      = PH_ECHO;
            rng_echo_ticks = '0;
         end
      end else if (rng_phase == PH_ECHO) begin
         if (rng_echo_ticks != ECHO_MAX) rng_echo_ticks++;
         if (hit_edge) begin
            mm = (64'(rng_echo_ticks) * TICKS_TO_MM) >> MM_SHIFT;
            rng_dist[ch]   = (mm > 64'hFFFF) ? 16'hFFFF : mm[OUT_DIST_W-1:0];
            rng_echo_seen  = 1'b1;
            rng_phase      = PH_HOLD;
            r.measure_done = 1'b1;
            rng_motor      = any_channel_in_window();
         end
      end

      rng_slot_count++;
      if (rng_slot_count >= shadow_regs[REG_SLOT_TICKS] || rng_slot_count == 0) begin
         if (!rng_echo_seen) begin
            rng_dist[ch]     = '0;
            r.slot_timed_out = 1'b1;
         end
         rng_channel    = (ch == MAX_CHANNELS - 1) ? '0 : ch + 1'b1;
         rng_phase      = PH_ARM;
         rng_echo_seen  = 1'b1;
         rng_slot_count = '0;
         rng_pulse_left = '0;
         slots_ended++;
      end

      r.motor_on       = rng_motor;
      r.active_channel = ch;
      r.distance_mm    = rng_dist[ch];
      return r;
   endfunction

   function automatic logic echo_may_start();
      return (rng_phase == PH_ARM && shadow_regs[REG_PULSE_TICKS][PULSE_W-1:0] == 0) ||
             (rng_phase == PH_PULSE && rng_pulse_left == 0);
   endfunction

   // other lines wander now and then; the active line toggles on request
   function automatic logic [ECHO_W-1:0] stir_levels(logic toggle_active);
      logic [ECHO_W-1:0] flip;
      flip = ECHO_W'($urandom) & ECHO_W'($urandom);
      flip[rng_channel] = toggle_active;
      return echo_lines ^ flip;
   endfunction

   // ------------------------------------------------------------------
   // stream sides
   // ------------------------------------------------------------------
   task automatic send_levels(logic [ECHO_W-1:0] levels);
      int gap;
      gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(8 - ECHO_W){1'b0}}, levels};
      do @(posedge clock); while (!req_tready);
      echo_lines = levels;
      n_sent++;
      expected_ticks.push_back(predict_ranging_tick(levels));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int w;
      forever begin
         w = sink_idle ? $urandom_range(0, IDLE_MAX) : 0;
         if (sink_hold > 0) begin
            w = sink_hold;
            sink_hold = 0;
         end
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic void compare_field(string name, logic [OUT_DIST_W-1:0] want,
                                         logic [OUT_DIST_W-1:0] got);
      if (got !== want) begin
         n_errors++;
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
   endfunction

   initial begin
      result_type got;
      result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata);
            if (expected_ticks.size() == 0) begin
               n_errors++;
               $display("%0t: item expected none got %h", $time, rsp_tdata);
            end else begin
               want = expected_ticks.pop_front();
               compare_field("trigger_levels", OUT_DIST_W'(want.trigger_levels),
                             OUT_DIST_W'(got.trigger_levels));
               compare_field("motor_on", OUT_DIST_W'(want.motor_on),
                             OUT_DIST_W'(got.motor_on));
               compare_field("measure_done", OUT_DIST_W'(want.measure_done),
                             OUT_DIST_W'(got.measure_done));
               compare_field("slot_timed_out", OUT_DIST_W'(want.slot_timed_out),
                             OUT_DIST_W'(got.slot_timed_out));
               compare_field("active_channel", OUT_DIST_W'(want.active_channel),
                             OUT_DIST_W'(got.active_channel));
               compare_field("distance_mm", want.distance_mm, got.distance_mm);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   function automatic void set_reg(logic [CFG_ADDR_W-1:0] idx, int unsigned value);
      pending_regs[idx] = CFG_DATA_W'(value);
   endfunction

   // 16-bit registers get junk in the unused upper write bits
   task automatic load_regs();
      logic [CFG_DATA_W-1:0] junk;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (i == REG_SLOT_TICKS) begin
            junk = '0;
            shadow_regs[i] = pending_regs[i];
         end else begin
            junk = CFG_DATA_W'($urandom) & ~CFG_DATA_W'(16'hFFFF);
            shadow_regs[i] = CFG_DATA_W'(pending_regs[i][WIN_W-1:0]);
         end
         csr_we    <= 1'b1;
         csr_addr  <= CFG_ADDR_W'(i);
         csr_wdata <= shadow_regs[i] | junk;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_windows();
      set_reg(REG_WIN0_LOW,  $urandom_range(0, 65535));
      set_reg(REG_WIN0_HIGH, $urandom_range(0, 65535));
      set_reg(REG_WIN1_LOW,  $urandom_range(0, 65535));
      set_reg(REG_WIN1_HIGH, $urandom_range(0, 65535));
      set_reg(REG_WIN2_LOW,  $urandom_range(0, 65535));
      set_reg(REG_WIN2_HIGH, $urandom_range(0, 65535));
   endtask

   // one slot of the active channel, from its start to its end
   task automatic range_one_slot(int kind, int echo_len);
      int slot_id;
      while (rng_phase != PH_ARM) send_levels(stir_levels(1'b1));
      slot_id = slots_ended;
      // toggles during the pulse must be ignored
      while (slots_ended == slot_id && !echo_may_start())
         send_levels(stir_levels($urandom_range(0, 3) == 0));
      if (kind != SLOT_SILENT && slots_ended == slot_id) send_levels(stir_levels(1'b1));
      repeat (echo_len)
         if (slots_ended == slot_id) send_levels(stir_levels(1'b0));
      if (kind == SLOT_FULL && slots_ended == slot_id) send_levels(stir_levels(1'b1));
      while (slots_ended == slot_id)
         send_levels(stir_levels(kind == SLOT_FULL && $urandom_range(0, 3) == 0));
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_reset_values();
      send_levels(3'b000);
      send_levels(3'b111);
      send_levels(3'b101);
   endtask

   task automatic test_register_extremes();
      drain_results();
      // zero slot length: every tick closes a slot; no pulse
      set_reg(REG_SLOT_TICKS, 0);
      set_reg(REG_PULSE_TICKS, 0);
      set_reg(REG_WIN0_LOW, 0);
      set_reg(REG_WIN0_HIGH, 'hFFFF);
      set_reg(REG_WIN1_LOW, 0);
      set_reg(REG_WIN1_HIGH, 'hFFFF);
      set_reg(REG_WIN2_LOW, 0);
      set_reg(REG_WIN2_HIGH, 'hFFFF);
      load_regs();
      send_levels(3'b111);
      send_levels(3'b000);
      send_levels(3'b111);
      drain_results();
      // one-tick slots with the longest pulse
      set_reg(REG_SLOT_TICKS, 1);
      set_reg(REG_PULSE_TICKS, 'hFFFF);
      set_reg(REG_WIN0_LOW, 'hFFFF);
      set_reg(REG_WIN0_HIGH, 0);
      set_reg(REG_WIN1_LOW, 'hFFFF);
      set_reg(REG_WIN1_HIGH, 0);
      set_reg(REG_WIN2_LOW, 'hFFFF);
      set_reg(REG_WIN2_HIGH, 0);
      load_regs();
      send_levels(3'b000);
      send_levels(3'b111);
      send_levels(3'b010);
      drain_results();
      // longest slot, shortest nonzero pulse, shortest echo, late edge
      set_reg(REG_SLOT_TICKS, 'h1FFFFFF);
      set_reg(REG_PULSE_TICKS, 1);
      set_reg(REG_WIN0_LOW, 0);
      set_reg(REG_WIN0_HIGH, 'hFFFF);
      load_regs();
      send_levels(stir_levels(1'b1));
      send_levels(stir_levels(1'b1));
      send_levels(stir_levels(1'b0));
      send_levels(stir_levels(1'b1));
      send_levels(stir_levels(1'b1));
   endtask

   task automatic test_ranging();
      int start;
      int pick;
      int kind;
      for (int s = 0; s < 6; s++) begin
         drain_results();
         src_idle  = (s == 1) ? 1'b0 : (s == 2) ? 1'b1 : 1'($urandom_range(0, 1));
         sink_idle = (s == 1) ? 1'b0 : (s == 2) ? 1'b1 : 1'($urandom_range(0, 1));
         set_reg(REG_SLOT_TICKS, (s == 0) ? $urandom_range(1, 4) : $urandom_range(8, 24));
         set_reg(REG_PULSE_TICKS, $urandom_range(0, 6));
         random_windows();
         load_regs();
         start = n_sent;
         while (n_sent - start < 12) begin
            pick = $urandom_range(0, 9);
            kind = (pick == 8) ? SLOT_SILENT : (pick == 9) ? SLOT_OPEN : SLOT_FULL;
            range_one_slot(kind, $urandom_range(0, 20));
         end
      end
   endtask

   // echo long enough for a distance of one mm, or just short of it
   task automatic test_window_hits();
      drain_results();
      src_idle  = 1'b0;
      sink_idle = 1'($urandom_range(0, 1));
      set_reg(REG_SLOT_TICKS, 250);
      set_reg(REG_PULSE_TICKS, 2);
      set_reg(REG_WIN0_LOW, 0);
      set_reg(REG_WIN0_HIGH, 2);
      set_reg(REG_WIN1_LOW, 0);
      set_reg(REG_WIN1_HIGH, 2);
      set_reg(REG_WIN2_LOW, 0);
      set_reg(REG_WIN2_HIGH, 'hFFFF);
      load_regs();
      range_one_slot(SLOT_FULL, $urandom_range(230, 240));
   endtask

   task automatic test_echo_noise();
      drain_results();
      src_idle  = 1'b1;
      sink_idle = 1'b1;
      set_reg(REG_SLOT_TICKS, $urandom_range(8, 40));
      set_reg(REG_PULSE_TICKS, $urandom_range(0, 3));
      random_windows();
      load_regs();
      repeat (25) send_levels(ECHO_W'($urandom));
   endtask

   task automatic test_backpressure();
      int start;
      drain_results();
      src_idle  = 1'b0;
      sink_idle = 1'b0;
      set_reg(REG_SLOT_TICKS, 12);
      set_reg(REG_PULSE_TICKS, 1);
      load_regs();
      sink_hold = 60;
      start = n_sent;
      while (n_sent - start < 20) range_one_slot(SLOT_FULL, $urandom_range(0, 6));
      drain_results();
      src_idle  = 1'b1;
      sink_idle = 1'b1;
      start = n_sent;
      while (n_sent - start < 12) range_one_slot(SLOT_FULL, $urandom_range(0, 6));
   endtask

   initial begin
      ranging_reset();
      pending_regs = shadow_regs;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_register_extremes();
      test_ranging();
      test_window_hits();
      test_echo_noise();
      test_backpressure();
      drain_results();
      if (n_errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/merc_pkg.sv
hdl/merc_cfg_regs.sv
hdl/merc_range_core.sv
hdl/merc_out_skid.sv
hdl/multi_channel_echo_ranging_controller_core.sv
bench/tb_top.sv
